// ===== rtl/rpa_pkg.sv =====
// Shared constants, codes and item types of the page allocator.
`default_nettype none
package rpa_pkg;

   // Geometry
   localparam int NUM_PAGES  = 65536;
   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PAGE_W     = $clog2(NUM_PAGES);
   localparam int DEPTH_W    = PAGE_W + 1;

   // Field widths
   localparam int OP_W      = 2;
   localparam int ADDR_W    = 32;
   localparam int AMOUNT_W  = 16;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 16;
   localparam int FREE_W    = 17;
   localparam int FIRST_W   = 16;
   localparam int COUNT_MAX = 65535;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_FIRST_PAGE = 1'b0;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]            operation;
      logic [ADDR_W-1:0]          address;
      logic signed [AMOUNT_W-1:0] amount;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   page_address;
      logic [COUNT_W-1:0]  ref_count;
      logic [FREE_W-1:0]   free_count;
   } rsp_item_type;

   // Controller to datapath
   typedef struct packed {
      logic              clear;
      logic [PAGE_W-1:0] clear_addr;
      logic              accept;
      logic              exec;
   } rpa_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic skid_full;
   } rpa_stat_type;

endpackage
`default_nettype wire

// ===== rtl/refcounted_page_allocator.sv =====
// Top level of the reference-counted page allocator.
// Results: registered in the output register, or in the skid entry if stalled.
// Items: one at a time, set by the read-modify-write of the count table
//   RAM (read at acceptance, write in the execute cycle).
// Reset: synchronous; afterwards a sweep zeroes every count table entry
//   with req_ready low; configuration writes are taken throughout.
`default_nettype none
module refcounted_page_allocator
   import rpa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_item_type          req_item,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_item_type               rsp_item,
   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   rpa_cmd_type         cmd;
   rpa_stat_type        stat;
   logic [FIRST_W-1:0]  first_page_ff, first_page_in;
   logic                csr_write;
   logic [CSR_ADDR_W-3:0] csr_index;

   // Register file: first_page only; other word addresses read as zero
   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      first_page_in = first_page_ff;
      if (csr_write && (csr_index == REG_FIRST_PAGE)) begin
         first_page_in = pwdata[FIRST_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_index == REG_FIRST_PAGE) begin
         prdata = CSR_DATA_W'(first_page_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= '0;
      end else begin
         first_page_ff <= first_page_in;
      end
   end

   // Sequencer: clear sweep, idle, execute
   rpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Memories, free list pointers and result buffering
   rpa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_item   (req_item),
      .first_page (first_page_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule
`default_nettype wire

// ===== rtl/rpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/rpa_ctrl.sv =====
// Controller: count table clearing sweep and per-item sequencing.
`default_nettype none
module rpa_ctrl
   import rpa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire rpa_stat_type stat,
   output rpa_cmd_type       cmd
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [PAGE_W-1:0] clear_addr_ff, clear_addr_in;

   assign req_ready = (state_ff == S_IDLE) && !stat.skid_full;

   always_comb begin
      cmd.clear      = (state_ff == S_CLEAR);
      cmd.clear_addr = clear_addr_ff;
      cmd.accept     = req_valid && req_ready;
      cmd.exec       = (state_ff == S_EXEC);
   end

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clear_addr_in = clear_addr_ff + PAGE_W'(1);
            if (&clear_addr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd.accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rpa_dp.sv =====
// Datapath: count table, returned-page stack, free list pointers, result buffers.
`default_nettype none
module rpa_dp
   import rpa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rpa_cmd_type        cmd,
   output rpa_stat_type            stat,
   input  wire req_item_type       req_item,
   input  wire logic [FIRST_W-1:0] first_page,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_item_type            rsp_item
);

   req_item_type       item_ff;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [DEPTH_W-1:0] fresh_ff, fresh_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;
   logic               skid_valid_ff, skid_valid_in;
   rsp_item_type       skid_item_ff, skid_item_in;

   // Memory ports
   logic               ref_we;
   logic [PAGE_W-1:0]  ref_wa, ref_ra;
   logic [COUNT_W-1:0] ref_wd, ref_rd;
   logic               stk_we;
   logic [PAGE_W-1:0]  stk_wa, stk_wd, stk_rd;
   logic [DEPTH_W-1:0] stk_top;

   // Item decode
   logic [ADDR_W-1:0]  page_full;
   logic [PAGE_W-1:0]  page_idx;
   logic               above_top;
   logic [DEPTH_W-1:0] first_ext;
   logic signed [COUNT_W+1:0] sum_s;
   logic [COUNT_W-1:0] count_dec;
   logic [DEPTH_W-1:0] fresh_avail;
   rsp_item_type       res;
   logic               rsp_fire;

   assign ref_ra  = req_item.address[PAGE_SHIFT +: PAGE_W];
   assign stk_top = depth_ff - DEPTH_W'(1);

   rpa_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_PAGES)) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_wa),
      .wr_data (ref_wd),
      .rd_en   (cmd.accept),
      .rd_addr (ref_ra),
      .rd_data (ref_rd)
   );

   rpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_en   (cmd.accept),
      .rd_addr (stk_top[PAGE_W-1:0]),
      .rd_data (stk_rd)
   );

   assign page_full = item_ff.address >> PAGE_SHIFT;
   assign page_idx  = page_full[PAGE_W-1:0];
   assign above_top = page_full >= ADDR_W'(NUM_PAGES);
   assign first_ext = DEPTH_W'(first_page);
   assign sum_s     = $signed({2'b00, ref_rd}) + (COUNT_W+2)'(item_ff.amount);
   assign count_dec = ref_rd - COUNT_W'(1);

   // Clear sweep write of the count table, else execute: one read-modify-write of both memories
   always_comb begin
      ref_we           = 1'b0;
      ref_wa           = page_idx;
      ref_wd           = '0;
      stk_we           = 1'b0;
      stk_wa           = depth_ff[PAGE_W-1:0];
      stk_wd           = page_idx;
      depth_in         = depth_ff;
      fresh_in         = fresh_ff;
      res.status       = ST_OK;
      res.page_address = '0;
      res.ref_count    = '0;
      if (cmd.clear) begin
         ref_we = 1'b1;
         ref_wa = cmd.clear_addr;
      end else if (cmd.exec) begin
         unique case (item_ff.operation)
            OP_ALLOC: begin
               if (depth_ff != '0) begin
                  depth_in = stk_top;
                  ref_wa   = stk_rd;
               end else if (fresh_ff > first_ext) begin
                  fresh_in = fresh_ff - DEPTH_W'(1);
                  ref_wa   = fresh_in[PAGE_W-1:0];
               end else begin
                  res.status = ST_EMPTY;
               end
               if (res.status == ST_OK) begin
                  ref_we           = 1'b1;
                  ref_wd           = COUNT_W'(1);
                  res.ref_count    = COUNT_W'(1);
                  res.page_address = ADDR_W'(ref_wa) << PAGE_SHIFT;
               end
            end
            OP_FREE: begin
               if (item_ff.address[PAGE_SHIFT-1:0] != '0) begin
                  res.status = ST_MISALIGNED;
               end else if (above_top || (page_full < ADDR_W'(first_page))) begin
                  res.status = ST_RANGE;
               end else if (ref_rd == '0) begin
                  res.status = ST_ALREADY_FREE;
               end else begin
                  ref_we        = 1'b1;
                  ref_wd        = count_dec;
                  res.ref_count = count_dec;
                  // last reference gone: push unless the stack is full
                  if ((count_dec == '0) && (depth_ff < DEPTH_W'(NUM_PAGES))) begin
                     stk_we   = 1'b1;
                     depth_in = depth_ff + DEPTH_W'(1);
                  end
               end
            end
            OP_ADD, OP_READ: begin
               if (above_top) begin
                  res.status = ST_RANGE;
               end else if (item_ff.operation == OP_ADD) begin
                  ref_we = 1'b1;
                  if (sum_s < 0) begin
                     ref_wd = '0;
                  end else if (sum_s > $signed((COUNT_W+2)'(COUNT_MAX))) begin
                     ref_wd = COUNT_W'(COUNT_MAX);
                  end else begin
                     ref_wd = sum_s[COUNT_W-1:0];
                  end
                  res.ref_count = ref_wd;
               end else begin
                  res.ref_count = ref_rd;
               end
            end
            default: begin
               res.status = ST_OK;
            end
         endcase
      end
      // free count after the operation, fresh region clipped at first_page
      fresh_avail    = (fresh_in > first_ext) ? (fresh_in - first_ext) : '0;
      res.free_count = FREE_W'(depth_in + fresh_avail);
   end

   // Output register plus one skid entry
   assign rsp_fire = rsp_valid_ff && rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_item_in   = rsp_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff && rsp_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_item_in   = skid_item_ff;
         skid_valid_in = 1'b0;
      end
      if (cmd.exec) begin
         if (!rsp_valid_ff || rsp_fire) begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_item_in  = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= '0;
         fresh_ff      <= DEPTH_W'(NUM_PAGES);
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         depth_ff      <= depth_in;
         fresh_ff      <= fresh_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_item;
      end
      rsp_item_ff  <= rsp_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign stat.skid_full = skid_valid_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item       = rsp_item_ff;

endmodule
`default_nettype wire

// ===== rtl/rpa_checker.sv =====
// Port-level assertions for the page allocator and their bind.
`default_nettype none
module rpa_checker
   import rpa_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire rsp_item_type rsp_item
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // one item at a time: no acceptance in the cycle after one
   a_no_b2b: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted in back-to-back cycles");

   // a new result only follows a busy cycle
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without an item at work");

   // failed operations carry no page and no count
   a_fail_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != ST_OK) |->
         (rsp_item.page_address == '0) && (rsp_item.ref_count == '0))
      else $error("failed item carries a page or count");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);
`default_nettype wire
